@@ sv/gett_pkg.sv @@
// Shared constants, register codes and stage payload types for the turn tracker.
package gett_pkg;

   localparam int READING_BITS  = 16;
   localparam int FRACTION_BITS = 16;
   localparam int LENGTH_BITS   = 17;
   localparam int DPC_BITS      = 32;
   localparam int MODE_BITS     = 2;
   localparam int TURN_BITS     = 32;
   localparam int SEL_BITS      = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 128;

   // 360 fits in 9 integer bits
   localparam int FRAC_BITS    = 9 + FRACTION_BITS;
   localparam int DIFF_BITS    = LENGTH_BITS + 2;
   localparam int DELTA_BITS   = LENGTH_BITS + 1;
   localparam int PRODUCT_BITS = DELTA_BITS + DPC_BITS + 1;
   localparam int SUM_BITS     = PRODUCT_BITS + 1;

   localparam logic [FRAC_BITS-1:0] FULL_TURN = FRAC_BITS'(64'd360 << FRACTION_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENCODER_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEGREES_PER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_MODE        = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_RAW   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TURN  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TOTAL = 2'd2;

   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 17'd8192;
   localparam logic [DPC_BITS-1:0]    DPC_RESET    = 32'd2880;
   localparam logic [MODE_BITS-1:0]   MODE_RESET   = MODE_TURN;

   typedef struct packed {
      logic                           first;
      logic [READING_BITS-1:0]        reading;
      logic signed [DELTA_BITS-1:0]   delta;
   } delta_item_type;

   typedef struct packed {
      logic                    first;
      logic [READING_BITS-1:0] reading;
      logic [FRAC_BITS-1:0]    frac;
      logic [TURN_BITS-1:0]    turns;
   } track_item_type;

endpackage

@@ sv/gett_accum.sv @@
// Scale stage and angle accumulator with wrap into one turn and turn counting.
module gett_accum
   import gett_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DPC_BITS-1:0]   degrees_per_count,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  delta_item_type        in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output track_item_type        out_item
);

   logic                           c_valid_ff;
   logic                           c_first_ff;
   logic [READING_BITS-1:0]        c_reading_ff;
   logic signed [PRODUCT_BITS-1:0] c_product_ff;
   logic signed [PRODUCT_BITS-1:0] product_in;
   logic signed [DPC_BITS:0]       dpc_s;

   logic                           d_valid_ff;
   track_item_type                 track_ff;
   track_item_type                 track_in;

   logic                           c_load;
   logic                           d_load;

   logic signed [SUM_BITS-1:0]     sum;
   logic signed [SUM_BITS-1:0]     wrapped;
   logic signed [SUM_BITS-1:0]     full_s;
   logic signed [SUM_BITS-1:0]     frac_s;

   assign d_load   = !d_valid_ff || out_ready;
   assign c_load   = !c_valid_ff || d_load;
   assign in_ready = c_load;

   assign dpc_s      = signed'({1'b0, degrees_per_count});
   assign product_in = in_item.delta * dpc_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_load) begin
         c_valid_ff <= in_valid;
      end
      if (c_load && in_valid) begin
         c_first_ff   <= in_item.first;
         c_reading_ff <= in_item.reading;
         c_product_ff <= product_in;
      end
   end

   assign full_s = signed'({(SUM_BITS-FRAC_BITS)'(0), FULL_TURN});
   assign frac_s = signed'({(SUM_BITS-FRAC_BITS)'(0), track_ff.frac});
   assign sum    = SUM_BITS'(c_product_ff) + frac_s;

   always_comb begin
      track_in.first   = c_first_ff;
      track_in.reading = c_reading_ff;
      track_in.turns   = track_ff.turns;
      wrapped          = sum;
      if (sum >= full_s) begin
         wrapped        = sum - full_s;
         track_in.turns = track_ff.turns + TURN_BITS'(1);
      end else if (sum < 0) begin
         wrapped        = sum + full_s;
         track_in.turns = track_ff.turns - TURN_BITS'(1);
      end
      // steps larger than one turn saturate
      if (wrapped < 0) begin
         track_in.frac = '0;
      end else if (wrapped >= full_s) begin
         track_in.frac = FULL_TURN - FRAC_BITS'(1);
      end else begin
         track_in.frac = wrapped[FRAC_BITS-1:0];
      end
      if (c_first_ff) begin
         track_in.frac  = '0;
         track_in.turns = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_load) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_load && c_valid_ff) begin
         track_ff <= track_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = track_ff;

endmodule

@@ sv/geared_encoder_turn_tracker_unit.sv @@
// Top level: multi-turn output shaft angle tracker for a geared rotor encoder.
//
// req_* carries one raw encoder reading per transaction; rsp_* returns one
// result per reading, in order. csr_* writes the configuration registers
// (0 encoder length, 1 degrees per count, 2 angle mode); it is always ready.
// It must be written only while no reading is in flight; the block does not enforce this.
// The first reading after reset only seeds the tracker and is flagged in
// rsp_tuser; later readings unwrap the shortest encoder delta, scale it and
// accumulate the shaft angle and the signed turn count.
// Five register stages: input register, wrapped delta, 18x33 scale multiply,
// accumulate/wrap, output select, in that order from req to rsp.
// Throughput is one reading per cycle while rsp_tready is high; the accumulator loop is a single
// add-and-wrap stage, so readings may arrive back to back.
// Reset clears all stage valids and restores the register defaults
// (length 8192, 2880 per count, mode 1) and arms the first-reading seed.
// When rsp_tready is low each occupied stage holds; req_tready stays high until every
// stage between the ports is occupied.
module geared_encoder_turn_tracker_unit
   import gett_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // [15:0] encoder_angle
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [24:0] angle_in_turn, [56:25] turn_count,
                                                  // [120:57] selected_angle, rest zero
   output logic                      rsp_tuser,   // [0] first_sample
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [LENGTH_BITS-1:0]   length_ff;
   logic [DPC_BITS-1:0]      dpc_ff;
   logic [MODE_BITS-1:0]     mode_ff;

   logic                     first_ff;
   logic [READING_BITS-1:0]  prev_ff;

   logic                     a_valid_ff;
   logic                     a_first_ff;
   logic [READING_BITS-1:0]  a_reading_ff;
   logic [READING_BITS-1:0]  a_prev_ff;

   logic                     b_valid_ff;
   delta_item_type           b_item_ff;
   delta_item_type           b_item_in;

   logic                     acc_ready;
   logic                     acc_valid;
   track_item_type           acc_item;

   logic                     e_valid_ff;
   logic                     e_first_ff;
   logic [FRAC_BITS-1:0]     e_frac_ff;
   logic [TURN_BITS-1:0]     e_turns_ff;
   logic [SEL_BITS-1:0]      e_sel_ff;
   logic [SEL_BITS-1:0]      sel_in;
   logic [SEL_BITS-1:0]      turns_x;
   logic [SEL_BITS-1:0]      turns_360;

   logic                     a_load;
   logic                     b_load;
   logic                     e_load;
   logic                     req_fire;

   logic signed [DIFF_BITS-1:0] diff;
   logic signed [DIFF_BITS-1:0] twice;
   logic signed [DIFF_BITS-1:0] len_s;
   logic signed [DIFF_BITS-1:0] delta_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
         dpc_ff    <= DPC_RESET;
         mode_ff   <= MODE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENCODER_LENGTH:    length_ff <= csr_data[LENGTH_BITS-1:0];
            CSR_DEGREES_PER_COUNT: dpc_ff    <= csr_data[DPC_BITS-1:0];
            CSR_ANGLE_MODE:        mode_ff   <= csr_data[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign e_load     = !e_valid_ff || rsp_tready;
   assign b_load     = !b_valid_ff || acc_ready;
   assign a_load     = !a_valid_ff || b_load;
   assign req_tready = a_load;
   assign req_fire   = req_tvalid && a_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         first_ff   <= 1'b1;
      end else begin
         if (a_load) begin
            a_valid_ff <= req_tvalid;
         end
         if (req_fire) begin
            first_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         a_first_ff   <= first_ff;
         a_reading_ff <= req_tdata[READING_BITS-1:0];
         a_prev_ff    <= prev_ff;
         prev_ff      <= req_tdata[READING_BITS-1:0];
      end
   end

   // shortest wrapped delta; exactly half a turn counts positive
   assign diff  = signed'({(DIFF_BITS-READING_BITS)'(0), a_reading_ff})
                - signed'({(DIFF_BITS-READING_BITS)'(0), a_prev_ff});
   assign twice = diff <<< 1;
   assign len_s = signed'({(DIFF_BITS-LENGTH_BITS)'(0), length_ff});

   always_comb begin
      delta_wide = diff;
      if (diff >= 0) begin
         if (twice > len_s) begin
            delta_wide = diff - len_s;
         end
      end else if (twice <= -len_s) begin
         delta_wide = diff + len_s;
      end
      b_item_in.first   = a_first_ff;
      b_item_in.reading = a_reading_ff;
      b_item_in.delta   = delta_wide[DELTA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_load) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_load && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   gett_accum u_accum (
      .clock             (clock),
      .reset             (reset),
      .degrees_per_count (dpc_ff),
      .in_valid          (b_valid_ff),
      .in_ready          (acc_ready),
      .in_item           (b_item_ff),
      .out_valid         (acc_valid),
      .out_ready         (e_load),
      .out_item          (acc_item)
   );

   // 360 = 256 + 64 + 32 + 8
   assign turns_x   = SEL_BITS'(signed'(acc_item.turns));
   assign turns_360 = (turns_x << 8) + (turns_x << 6) + (turns_x << 5) + (turns_x << 3);

   always_comb begin
      case (mode_ff)
         MODE_RAW:   sel_in = SEL_BITS'(acc_item.reading);
         MODE_TURN:  sel_in = SEL_BITS'(acc_item.frac);
         MODE_TOTAL: sel_in = (turns_360 << FRACTION_BITS) + SEL_BITS'(acc_item.frac);
         default:    sel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_load) begin
         e_valid_ff <= acc_valid;
      end
      if (e_load && acc_valid) begin
         e_first_ff <= acc_item.first;
         e_frac_ff  <= acc_item.frac;
         e_turns_ff <= acc_item.turns;
         e_sel_ff   <= sel_in;
      end
   end

   assign rsp_tvalid = e_valid_ff;
   assign rsp_tuser  = e_first_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS-SEL_BITS-TURN_BITS-FRAC_BITS)'(0),
                        e_sel_ff, e_turns_ff, e_frac_ff};

endmodule

@@ verif/tb_geared_encoder_turn_tracker_unit.sv @@
// Self-checking testbench for the geared encoder turn tracker: directed and random readings.
module tb_geared_encoder_turn_tracker_unit;
   import gett_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_WAIT      = 18;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {OP_READING, OP_CSR, OP_DRAIN} sender_kind_type;

   typedef struct {
      sender_kind_type           kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      int                        gap;
   } sender_op_type;

   typedef struct packed {
      logic                   first;
      logic [FRAC_BITS-1:0]   angle;
      logic [TURN_BITS-1:0]   turns;
      logic [SEL_BITS-1:0]    sel;
   } tracker_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   geared_encoder_turn_tracker_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   sender_op_type      pending_ops[$];
   tracker_result_type predicted_results[$];
   int              readings_sent = 0;
   int              results_checked = 0;
   int              csr_writes = 0;
   int              mismatches = 0;
   int              mode_hits[4] = '{0, 0, 0, 0};
   int              cycle_count = 0;
   bit              burst_mode = 1'b0;

   // tracker state mirror
   logic [LENGTH_BITS-1:0]  trk_length = LENGTH_RESET;
   logic [DPC_BITS-1:0]     trk_dpc = DPC_RESET;
   logic [MODE_BITS-1:0]    trk_mode = MODE_RESET;
   logic                    trk_awaiting_first = 1'b1;
   logic [READING_BITS-1:0] trk_previous = '0;
   logic [FRAC_BITS-1:0]    trk_fraction = '0;
   logic [TURN_BITS-1:0]    trk_turns = '0;

   function automatic tracker_result_type advance_tracker(input logic [READING_BITS-1:0] reading);
      tracker_result_type r;
      longint diff;
      longint len;
      longint acc;
      longint full;
      len  = longint'(trk_length);
      full = longint'(FULL_TURN);
      r.first = trk_awaiting_first;
      if (trk_awaiting_first) begin
         trk_awaiting_first = 1'b0;
         trk_fraction = '0;
         trk_turns = '0;
      end else begin
         diff = longint'(reading) - longint'(trk_previous);
         if (diff >= 0) begin
            if (2 * diff > len) diff = diff - len;
         end else if (2 * diff <= -len) begin
            diff = diff + len;
         end
         acc = diff * longint'(trk_dpc) + longint'(trk_fraction);
         if (acc >= full) begin
            acc = acc - full;
            trk_turns = trk_turns + 1;
         end else if (acc < 0) begin
            acc = acc + full;
            trk_turns = trk_turns - 1;
         end
         if (acc < 0) acc = 0;
         if (acc > full - 1) acc = full - 1;
         trk_fraction = acc[FRAC_BITS-1:0];
      end
      trk_previous = reading;
      r.angle = trk_fraction;
      r.turns = trk_turns;
      case (trk_mode)
         MODE_RAW:   r.sel = SEL_BITS'(reading);
         MODE_TURN:  r.sel = SEL_BITS'(trk_fraction);
         MODE_TOTAL: r.sel = longint'(trk_fraction) + full * longint'($signed(trk_turns));
         default:    r.sel = '0;
      endcase
      mode_hits[trk_mode]++;
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic add_reading(input logic [READING_BITS-1:0] value);
      sender_op_type op;
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      op.kind  = OP_READING;
      op.index = '0;
      op.value = CSR_DATA_BITS'(value);
      op.gap   = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
      pending_ops.push_back(op);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] value);
      sender_op_type op;
      op.kind  = OP_CSR;
      op.index = index;
      op.value = value;
      op.gap   = 0;
      pending_ops.push_back(op);
   endtask

   task automatic add_drain();
      sender_op_type op;
      op.kind  = OP_DRAIN;
      op.index = '0;
      op.value = '0;
      op.gap   = 0;
      pending_ops.push_back(op);
   endtask

   // driver: readings and register writes
   int accepted_count = 0;
   int quiet_cycles = 0;
   int gap_count = 0;

   always @(posedge clock) begin : request_driver
      logic req_next;
      logic csr_next;
      logic settled;
      sender_op_type op;
      req_next = req_tvalid && !req_tready;
      csr_next = csr_valid && !csr_ready;
      if (!req_tvalid && accepted_count == results_checked) quiet_cycles++;
      else quiet_cycles = 0;
      settled = !req_tvalid && accepted_count == results_checked && quiet_cycles >= SETTLE_CYCLES;
      if (reset) begin
         req_next = 1'b0;
         csr_next = 1'b0;
      end else if (!req_next && !csr_next && pending_ops.size() != 0) begin
         op = pending_ops[0];
         case (op.kind)
            OP_READING: begin
               if (gap_count >= op.gap) begin
                  req_next = 1'b1;
                  req_tdata <= op.value[REQ_DATA_BITS-1:0];
                  void'(pending_ops.pop_front());
                  gap_count = 0;
               end else begin
                  gap_count++;
               end
            end
            OP_CSR: begin
               if (settled) begin
                  csr_next = 1'b1;
                  csr_index <= op.index;
                  csr_data <= op.value;
                  void'(pending_ops.pop_front());
               end
            end
            default: begin
               if (settled) void'(pending_ops.pop_front());
            end
         endcase
      end
      req_tvalid <= req_next;
      csr_valid <= csr_next;
   end

   // monitor: prediction, checking and result back-pressure
   int stall_left = 0;
   int stall_max = 0;
   int stretch_left = 0;

   always @(posedge clock) begin : result_monitor
      tracker_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h/%h", $time,
                        rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               flag_field("first_sample", 64'(want.first), 64'(rsp_tuser));
               flag_field("angle_in_turn", 64'(want.angle), 64'(rsp_tdata[FRAC_BITS-1:0]));
               flag_field("turn_count", 64'(want.turns),
                          64'(rsp_tdata[FRAC_BITS+TURN_BITS-1:FRAC_BITS]));
               flag_field("selected_angle", want.sel,
                          rsp_tdata[FRAC_BITS+TURN_BITS+SEL_BITS-1:FRAC_BITS+TURN_BITS]);
               flag_field("tdata padding", 64'd0,
                          64'(rsp_tdata[RSP_DATA_BITS-1:FRAC_BITS+TURN_BITS+SEL_BITS]));
               results_checked <= results_checked + 1;
            end
            if (stretch_left == 0) begin
               case ($urandom_range(0, 2))
                  0:       stall_max = 0;
                  1:       stall_max = 4;
                  default: stall_max = MAX_WAIT;
               endcase
               stretch_left = $urandom_range(20, 80);
            end else begin
               stretch_left--;
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENCODER_LENGTH:    trk_length = csr_data[LENGTH_BITS-1:0];
               CSR_DEGREES_PER_COUNT: trk_dpc = csr_data[DPC_BITS-1:0];
               CSR_ANGLE_MODE:        trk_mode = csr_data[MODE_BITS-1:0];
               default: ;
            endcase
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(advance_tracker(req_tdata[READING_BITS-1:0]));
            accepted_count <= accepted_count + 1;
            readings_sent++;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, predicted_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      int count;
      int len;
      int eff_len;
      int span;
      int step;
      int pos;
      int ratio;
      int drain_at;
      logic [READING_BITS-1:0] last;
      logic [DPC_BITS-1:0] dpc;
      logic [MODE_BITS-1:0] mode;

      // directed: seed, half turn both ways, wrap, out-of-range reading
      add_reading(16'h0064);
      add_reading(16'h0064);
      add_reading(16'h1064);
      add_reading(16'h0064);
      add_reading(16'h1FFF);
      add_reading(16'h0000);
      add_reading(16'hFFFF);
      add_reading(16'h0000);
      add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(MODE_RAW));
      add_reading(16'hFFFF);
      add_reading(16'hA5A5);
      add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(MODE_TOTAL));
      add_reading(16'h5A5A);
      add_reading(16'h0001);
      add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(MODE_UNUSED));
      add_reading(16'h8000);
      // step beyond a full turn saturates both ways
      add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(MODE_TOTAL));
      add_csr(CSR_DEGREES_PER_COUNT, 32'hFFFF_FFFF);
      add_reading(16'h8001);
      add_reading(16'h8000);
      add_reading(16'h7FFF);
      add_csr(CSR_DEGREES_PER_COUNT, 32'd0);
      add_reading(16'h1234);
      // zero length: plain difference; then lengths 1, 65536 and 131071
      add_csr(CSR_DEGREES_PER_COUNT, 32'd2880);
      add_csr(CSR_ENCODER_LENGTH, 32'd0);
      add_reading(16'hFFFF);
      add_reading(16'h0000);
      add_csr(CSR_ENCODER_LENGTH, 32'd1);
      add_reading(16'h0001);
      add_reading(16'hFFFE);
      add_csr(CSR_ENCODER_LENGTH, 32'd65536);
      add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(MODE_TURN));
      add_reading(16'h0000);
      add_reading(16'hFFFF);
      add_reading(16'h8000);
      add_csr(CSR_ENCODER_LENGTH, 32'h1FFFF);
      add_reading(16'h0000);
      last = 16'h0000;

      for (phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = 65536;
            2:       len = 0;
            3:       len = 131071;
            4:       len = 8192;
            5:       len = 16384;
            6:       len = 4096;
            default: len = $urandom_range(2, 65536);
         endcase
         eff_len = (len >= 1) ? len : 65536;
         case ($urandom_range(0, 9))
            0:       dpc = 32'd0;
            1:       dpc = 32'hFFFF_FFFF;
            2:       dpc = $urandom;
            default: begin
               ratio = $urandom_range(1, 64);
               dpc = DPC_BITS'((longint'(360) << FRACTION_BITS) /
                               (longint'(ratio) * longint'(eff_len)));
            end
         endcase
         n = $urandom_range(0, 9);
         mode = (n == 0) ? MODE_UNUSED : (n < 4) ? MODE_RAW : (n < 6) ? MODE_TURN : MODE_TOTAL;
         add_csr(CSR_ENCODER_LENGTH, CSR_DATA_BITS'(len));
         add_csr(CSR_DEGREES_PER_COUNT, dpc);
         add_csr(CSR_ANGLE_MODE, CSR_DATA_BITS'(mode));
         case ($urandom_range(0, 3))
            0:       span = eff_len / 64 + 1;
            1:       span = eff_len / 8 + 1;
            2:       span = eff_len / 2;
            default: span = eff_len;
         endcase
         count = $urandom_range(100, 120);
         drain_at = $urandom_range(10, count - 10);
         for (n = 0; n < count; n++) begin
            if (n == drain_at) add_drain();
            case ($urandom_range(0, 19))
               0, 1:    last = READING_BITS'($urandom_range(0, 65535));
               2:       ;
               default: begin
                  step = int'($urandom_range(0, 2 * span)) - span;
                  if ($urandom_range(0, 19) == 0)
                     step = ($urandom_range(0, 1) != 0) ? eff_len / 2 : -(eff_len / 2);
                  pos = int'(last) + step;
                  if (len >= 1 && len <= 65536) begin
                     pos = pos % len;
                     if (pos < 0) pos = pos + len;
                  end else begin
                     pos = pos & 32'hFFFF;
                  end
                  last = pos[READING_BITS-1:0];
               end
            endcase
            add_reading(last);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_ops.size() != 0 || req_tvalid || accepted_count != results_checked)
         @(negedge clock);
      repeat (12) @(negedge clock);

      $display("Covered %0d readings and %0d checked results over %0d register writes",
               readings_sent, results_checked, csr_writes);
      $display("Results per mode raw/turn/total/unused: %0d/%0d/%0d/%0d, mismatches: %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
